// ===== sv/assert_macros.svh =====
// Assertion macros used by the timer queue datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define DJTQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DJTQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DJTQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define DJTQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== sv/djtq_pkg.sv =====
// Types and constants of the deadline job timer queue.
`timescale 1ns / 1ps
package djtq_pkg;
  localparam int DEFAULT_QUEUE_DEPTH = 16;
  localparam int MAX_FIRES = 16;
  localparam int CNT_W = 4;
  localparam int TIME_W = 32;
  localparam int ID_W = 16;

  localparam logic OP_SCHED = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_FIRED  = 2'd1;
  localparam logic [1:0] KIND_FULL   = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0] due;
    logic [TIME_W-1:0] period;
    logic [ID_W-1:0]   ident;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FSCAN, ST_SACC, ST_SFULL, ST_TSCAN,
    ST_TWAIT, ST_TDEC, ST_TMID, ST_TUPD, ST_TLAST
  } state_t;

  typedef struct packed {
    logic cap_tick;
    logic cap_sched;
    logic scan_init;
    logic scan_en;
    logic upd;
    logic emit_mid;
    logic emit_last;
    logic sched_write;
    logic sched_full;
  } cmd_t;

  typedef struct packed {
    logic free_at_idx;
    logic found;
    logic have_pend;
    logic cnt_last;
    logic out_free;
  } sts_t;
endpackage

// ===== sv/djtq_if.sv =====
// Channel interfaces of the timer queue: job input and result output.
`timescale 1ns / 1ps
interface job_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] start_time;
  logic [31:0] period;
  modport source(output valid, operation, start_time, period, input ready);
  modport sink(input valid, operation, start_time, period, output ready);
endinterface

interface job_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] job_id;
  logic [31:0] fire_time;
  logic        last;
  modport source(output valid, kind, job_id, fire_time, last, input ready);
  modport sink(input valid, kind, job_id, fire_time, last, output ready);
endinterface

// ===== sv/djtq_ctrl.sv =====
// Controller state machine of the timer queue.
`timescale 1ns / 1ps
module djtq_ctrl import djtq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
  localparam int IW = $clog2(QUEUE_DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_op,
  output logic          in_ready,
  input  sts_t          sts,
  output cmd_t          cmd,
  output logic [IW-1:0] idx
);
  localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);

  state_t        st_r, st_nxt;
  logic [IW-1:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      idx_r <= '0;
    end else begin
      st_r  <= st_nxt;
      idx_r <= idx_nxt;
    end
  end

  assign idx = idx_r;

  always_comb begin
    st_nxt   = st_r;
    idx_nxt  = idx_r;
    cmd      = '0;
    in_ready = (st_r == ST_IDLE);
    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          idx_nxt = '0;
          if (in_op == OP_TICK) begin
            cmd.cap_tick  = 1'b1;
            cmd.scan_init = 1'b1;
            st_nxt        = ST_TSCAN;
          end else begin
            cmd.cap_sched = 1'b1;
            st_nxt        = ST_FSCAN;
          end
        end
      end
      ST_FSCAN: begin
        if (sts.free_at_idx) st_nxt = ST_SACC;
        else if (idx_r == LAST_IDX) st_nxt = ST_SFULL;
        else idx_nxt = idx_r + 1'b1;
      end
      ST_SACC: begin
        if (sts.out_free) begin
          cmd.sched_write = 1'b1;
          st_nxt          = ST_IDLE;
        end
      end
      ST_SFULL: begin
        if (sts.out_free) begin
          cmd.sched_full = 1'b1;
          st_nxt         = ST_IDLE;
        end
      end
      ST_TSCAN: begin
        cmd.scan_en = 1'b1;
        if (idx_r == LAST_IDX) st_nxt = ST_TWAIT;
        else idx_nxt = idx_r + 1'b1;
      end
      ST_TWAIT: st_nxt = ST_TDEC;
      ST_TDEC: begin
        if (sts.found) st_nxt = sts.have_pend ? ST_TMID : ST_TUPD;
        else st_nxt = sts.have_pend ? ST_TLAST : ST_IDLE;
      end
      ST_TMID: begin
        // release the previous fire, it is known not to be the final one
        if (sts.out_free) begin
          cmd.emit_mid = 1'b1;
          st_nxt       = ST_TUPD;
        end
      end
      ST_TUPD: begin
        cmd.upd = 1'b1;
        if (sts.cnt_last) begin
          st_nxt = ST_TLAST;
        end else begin
          cmd.scan_init = 1'b1;
          idx_nxt       = '0;
          st_nxt        = ST_TSCAN;
        end
      end
      ST_TLAST: begin
        if (sts.out_free) begin
          cmd.emit_last = 1'b1;
          st_nxt        = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end
endmodule

// ===== sv/djtq_dp.sv =====
// Datapath of the timer queue: job memory, best-job search and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module djtq_dp import djtq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
  localparam int IW = $clog2(QUEUE_DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  logic [IW-1:0]     idx,
  output sts_t              sts,
  input  logic [TIME_W-1:0] in_start,
  input  logic [TIME_W-1:0] in_period,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [1:0]        out_kind,
  output logic [ID_W-1:0]   out_job_id,
  output logic [TIME_W-1:0] out_fire_time,
  output logic              out_last
);
  entry_t mem_r [QUEUE_DEPTH];
  entry_t rdata_r;

  logic [QUEUE_DEPTH-1:0] valid_r, fired_r;
  logic [TIME_W-1:0]      cur_time_r, start_r, period_r;
  logic [ID_W-1:0]        next_id_r;
  logic                   cmp_v_r;
  logic [IW-1:0]          cmp_idx_r;
  logic                   best_found_r;
  entry_t                 best_r;
  logic [IW-1:0]          best_idx_r;
  logic                   pend_r;
  logic [ID_W-1:0]        pend_id_r;
  logic [TIME_W-1:0]      pend_due_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   out_valid_r, out_last_r;
  logic [1:0]             out_kind_r;
  logic [ID_W-1:0]        out_id_r;
  logic [TIME_W-1:0]      out_time_r;

  logic   out_free, cand, better, wr_en, load;
  logic [IW-1:0] wr_addr;
  entry_t wr_data;

  assign out_free = !out_valid_r || out_ready;
  assign load = cmd.emit_mid || cmd.emit_last || cmd.sched_write || cmd.sched_full;

  assign cand = cmp_v_r && valid_r[cmp_idx_r] && !fired_r[cmp_idx_r]
                && (rdata_r.due <= cur_time_r);
  assign better = !best_found_r || (rdata_r.due < best_r.due)
                  || ((rdata_r.due == best_r.due) && (rdata_r.ident < best_r.ident));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = '{due: start_r, period: period_r, ident: next_id_r};
    if (cmd.sched_write) begin
      wr_en = 1'b1;
    end else if (cmd.upd && (best_r.period != '0)) begin
      wr_en   = 1'b1;
      wr_addr = best_idx_r;
      wr_data = '{due: best_r.due + best_r.period, period: best_r.period,
                  ident: best_r.ident};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    if (cmd.scan_en) rdata_r <= mem_r[idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      fired_r      <= '0;
      cur_time_r   <= '0;
      next_id_r    <= '0;
      cmp_v_r      <= 1'b0;
      best_found_r <= 1'b0;
      pend_r       <= 1'b0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      cmp_v_r <= cmd.scan_en;
      if (cmd.cap_tick) begin
        cur_time_r <= cur_time_r + 1'b1;
        fired_r    <= '0;
        pend_r     <= 1'b0;
        cnt_r      <= '0;
      end
      if (cmd.scan_init) best_found_r <= 1'b0;
      else if (cand && better) best_found_r <= 1'b1;
      if (cmd.upd) begin
        fired_r[best_idx_r] <= 1'b1;
        if (best_r.period == '0) valid_r[best_idx_r] <= 1'b0;
        pend_r <= 1'b1;
        cnt_r  <= cnt_r + 1'b1;
      end
      if (cmd.emit_last) pend_r <= 1'b0;
      if (cmd.sched_write) begin
        valid_r[idx] <= 1'b1;
        next_id_r    <= next_id_r + 1'b1;
      end
      if (load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= idx;
    if (cmd.cap_sched) begin
      start_r  <= in_start;
      period_r <= in_period;
    end
    if (cand && better && !cmd.scan_init) begin
      best_r     <= rdata_r;
      best_idx_r <= cmp_idx_r;
    end
    if (cmd.upd) begin
      pend_id_r  <= best_r.ident;
      pend_due_r <= best_r.due;
    end
    if (cmd.emit_mid || cmd.emit_last) begin
      out_kind_r <= KIND_FIRED;
      out_id_r   <= pend_id_r;
      out_time_r <= pend_due_r;
      out_last_r <= cmd.emit_last;
    end else if (cmd.sched_write) begin
      out_kind_r <= KIND_ACCEPT;
      out_id_r   <= next_id_r;
      out_time_r <= '0;
      out_last_r <= 1'b1;
    end else if (cmd.sched_full) begin
      out_kind_r <= KIND_FULL;
      out_id_r   <= '0;
      out_time_r <= '0;
      out_last_r <= 1'b1;
    end
  end

  assign sts.free_at_idx = !valid_r[idx];
  assign sts.found       = best_found_r;
  assign sts.have_pend   = pend_r;
  assign sts.cnt_last    = (cnt_r == CNT_W'(MAX_FIRES - 1));
  assign sts.out_free    = out_free;

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_job_id    = out_id_r;
  assign out_fire_time = out_time_r;
  assign out_last      = out_last_r;

  `DJTQ_ASSERT(a_cmd_excl, clk, rst_n,
    $onehot0({cmd.upd, cmd.emit_mid, cmd.emit_last, cmd.sched_write, cmd.sched_full}),
    "conflicting datapath commands")
  `DJTQ_ASSERT(a_mid_pend, clk, rst_n, (cmd.emit_mid || cmd.emit_last) |-> pend_r,
    "fire emitted with no pending job")
  `DJTQ_ASSERT(a_upd_found, clk, rst_n, cmd.upd |-> best_found_r,
    "update with no selected job")
  `DJTQ_ASSERT_NEVER(a_load_room, clk, rst_n, load && !out_free,
    "result register overwritten")
endmodule

// ===== sv/deadline_job_timer_queue.sv =====
// Top level of the deadline job timer queue.
// Usage:
//   in_ch carries one item per valid/ready handshake: operation 0 schedules a
//   job (start_time, period; period 0 = one-shot), operation 1 is one tick.
//   out_ch returns results: kind accept/fired/full, job_id, fire_time, last.
//   A schedule item gives exactly one result; a tick gives zero to sixteen
//   fired results in due-time order, the final one flagged by last.
// Sequencing:
//   schedule: a walk over the slot valid bits, ending at a free slot or the last slot.
//   tick: one scan of the job memory through its single read port per
//   fired job, plus one final scan unless the fire limit is reached;
//   a stalled receiver can hold back each result.
//   A new item is taken once the previous one is done, even while its last
//   result still waits in the output register.
// Reset clears the table, the time and the id counter; there is no
// clearing pass. A stalled receiver holds the result register and the
// controller waits before loading the next result.
`timescale 1ns / 1ps
module deadline_job_timer_queue import djtq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  job_in_if.sink     in_ch,
  job_out_if.source  out_ch
);
  localparam int IW = $clog2(QUEUE_DEPTH);

  cmd_t          cmd;
  sts_t          sts;
  logic [IW-1:0] idx;

  djtq_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.operation),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd),
    .idx      (idx)
  );

  djtq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .idx           (idx),
    .sts           (sts),
    .in_start      (in_ch.start_time),
    .in_period     (in_ch.period),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_kind      (out_ch.kind),
    .out_job_id    (out_ch.job_id),
    .out_fire_time (out_ch.fire_time),
    .out_last      (out_ch.last)
  );
endmodule

// ===== tb/deadline_job_timer_queue_test.sv =====
// Testbench of the deadline job timer queue: directed table plus random items, predictor-checked.
`timescale 1ns / 1ps
module deadline_job_timer_queue_test;
  import djtq_pkg::*;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 200;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] job_id;
    logic [31:0] fire_time;
    logic        last;
  } result_t;

  typedef struct {
    logic        op;
    logic [31:0] start_time;
    logic [31:0] period;
    bit          typed;
    result_t     res;
  } stim_row_t;

  logic clk;
  logic rst_n;
  job_in_if  in_ch();
  job_out_if out_ch();

  deadline_job_timer_queue #(.QUEUE_DEPTH(DEPTH)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // Predicted job table
  logic [31:0] job_due [DEPTH];
  logic [31:0] job_period [DEPTH];
  logic [15:0] job_ident [DEPTH];
  bit          job_valid [DEPTH];
  logic [31:0] now_ticks;
  logic [15:0] next_job_id;

  result_t pending_results[$];
  bit      typed_pending[$];
  result_t typed_results[$];

  int error_count, item_count, result_count, fire_count, full_count, cycle_count;
  int send_idle_pct, recv_idle_pct;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void schedule_or_tick(logic op, logic [31:0] start_time,
                                           logic [31:0] period);
    result_t r;
    result_t fires[$];
    bit fired [DEPTH];
    int best;
    if (op == OP_SCHED) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (!job_valid[i]) begin
          job_valid[i] = 1'b1;
          job_due[i] = start_time;
          job_period[i] = period;
          job_ident[i] = next_job_id;
          r = '{KIND_ACCEPT, next_job_id, 32'd0, 1'b1};
          pending_results.push_back(r);
          next_job_id = next_job_id + 16'd1;
          return;
        end
      end
      r = '{KIND_FULL, 16'd0, 32'd0, 1'b1};
      pending_results.push_back(r);
      return;
    end
    now_ticks = now_ticks + 32'd1;
    foreach (fired[i]) fired[i] = 1'b0;
    for (int n = 0; n < MAX_FIRES; n++) begin
      best = -1;
      for (int i = 0; i < DEPTH; i++) begin
        if (!job_valid[i] || fired[i] || job_due[i] > now_ticks) continue;
        // ties on due time go to the lower id, then the lower slot
        if (best < 0 || job_due[i] < job_due[best] ||
            (job_due[i] == job_due[best] && job_ident[i] < job_ident[best]))
          best = i;
      end
      if (best < 0) break;
      fired[best] = 1'b1;
      r = '{KIND_FIRED, job_ident[best], job_due[best], 1'b0};
      fires.push_back(r);
      if (job_period[best] == 32'd0) job_valid[best] = 1'b0;
      else job_due[best] = job_due[best] + job_period[best];
    end
    if (fires.size() > 0) fires[fires.size()-1].last = 1'b1;
    foreach (fires[i]) pending_results.push_back(fires[i]);
  endfunction

  // Accept items and results on the rising edge
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      item_count++;
      schedule_or_tick(in_ch.operation, in_ch.start_time, in_ch.period);
      if (typed_pending.size() > 0) begin
        if (typed_pending.pop_front()) begin
          // typed row replaces the predicted single result
          void'(pending_results.pop_back());
          pending_results.push_back(typed_results.pop_front());
        end
      end
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.kind, out_ch.job_id, out_ch.fire_time, out_ch.last};
      result_count++;
      if (got.kind == KIND_FIRED) fire_count++;
      if (got.kind == KIND_FULL) full_count++;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result kind=%0d id=%0d time=%0d last=%0b",
                   got.kind, got.job_id, got.fire_time, got.last);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: exp kind=%0d id=%0d time=%0d last=%0b, got kind=%0d id=%0d time=%0d last=%0b",
                     want.kind, want.job_id, want.fire_time, want.last,
                     got.kind, got.job_id, got.fire_time, got.last);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) out_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic send_item(logic op, logic [31:0] start_time, logic [31:0] period);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.operation = op;
    in_ch.start_time = start_time;
    in_ch.period = period;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    // a tick with nothing due may still be scanning
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_items(int count);
    logic [31:0] start_time, period;
    int pick;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 45) begin
        send_item(OP_TICK, $urandom, $urandom);
        continue;
      end
      pick = $urandom_range(0, 99);
      if (pick < 5) start_time = $urandom;
      else if (pick < 15 && now_ticks > 8) start_time = now_ticks - $urandom_range(1, 8);
      else start_time = now_ticks + $urandom_range(0, 12);
      pick = $urandom_range(0, 99);
      if (pick < 60) period = 32'd0;
      else if (pick < 85) period = $urandom_range(1, 8);
      else if (pick < 92) period = 32'hFFFF_FFFF - $urandom_range(0, 2);
      else period = $urandom;
      send_item(OP_SCHED, start_time, period);
    end
  endtask

  stim_row_t directed[$];

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_SCHED;
    in_ch.start_time = '0;
    in_ch.period = '0;
    out_ch.ready = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    error_count = 0; item_count = 0; result_count = 0;
    fire_count = 0; full_count = 0; cycle_count = 0;
    foreach (job_valid[i]) begin
      job_valid[i] = 1'b0; job_due[i] = '0; job_period[i] = '0; job_ident[i] = '0;
    end
    now_ticks = '0;
    next_job_id = '0;

    directed.push_back('{OP_SCHED, 32'd0, 32'd0, 1, '{KIND_ACCEPT, 16'd0, 32'd0, 1'b1}});
    directed.push_back('{OP_SCHED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                         '{KIND_ACCEPT, 16'd1, 32'd0, 1'b1}});
    directed.push_back('{OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                         '{KIND_FIRED, 16'd0, 32'd0, 1'b1}});
    // start already passed, recurring
    directed.push_back('{OP_SCHED, 32'd0, 32'd3, 1, '{KIND_ACCEPT, 16'd2, 32'd0, 1'b1}});
    // equal due times, lower id first
    directed.push_back('{OP_SCHED, 32'd2, 32'd0, 0, '{default: '0}});
    directed.push_back('{OP_SCHED, 32'd2, 32'd0, 0, '{default: '0}});
    directed.push_back('{OP_TICK, 32'd0, 32'd0, 0, '{default: '0}});
    directed.push_back('{OP_TICK, 32'd0, 32'd0, 0, '{default: '0}});
    for (int i = 0; i < 14; i++)
      directed.push_back('{OP_SCHED, 32'd5, (i % 2) ? 32'd1 : 32'd0, 0, '{default: '0}});
    directed.push_back('{OP_SCHED, 32'd7, 32'd7, 1, '{KIND_FULL, 16'd0, 32'd0, 1'b1}});
    // nothing due, then many due at once
    directed.push_back('{OP_TICK, 32'd0, 32'd0, 0, '{default: '0}});
    directed.push_back('{OP_TICK, 32'd0, 32'd0, 0, '{default: '0}});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) begin
      typed_pending.push_back(directed[i].typed);
      if (directed[i].typed) typed_results.push_back(directed[i].res);
      send_item(directed[i].op, directed[i].start_time, directed[i].period);
    end
    drain_results();

    send_idle_pct = 25; recv_idle_pct = 86;
    random_items(42);
    drain_results();
    send_idle_pct = 86; recv_idle_pct = 25;
    random_items(42);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_items(41);
    drain_results();

    $display("covered %0d items: %0d results, %0d jobs fired, %0d table-full answers",
             item_count, result_count, fire_count, full_count);
    $display("final tick count %0d, next job id %0d", now_ticks, next_job_id);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", error_count);
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
